>>> rtl/hdbc_pkg.sv
package hdbc_pkg;

    // Brightness word width; full scale is all ones.
    localparam int LEVEL_BITS = 10;
    localparam int MS_W       = 16;
    localparam int WAIT_W     = MS_W + 2;
    localparam int CFG_DATA_W = (LEVEL_BITS > MS_W) ? LEVEL_BITS : MS_W;
    localparam int CFG_IDX_W  = 3;

    localparam logic [LEVEL_BITS-1:0] LEVEL_FULL = {LEVEL_BITS{1'b1}};
    localparam logic [MS_W-1:0]       MS_MAX     = {MS_W{1'b1}};

    // Register reset values.
    localparam logic [MS_W-1:0]       RST_HOLD_DELAY    = MS_W'(500);
    localparam logic [MS_W-1:0]       RST_STEP_INTERVAL = MS_W'(100);
    localparam logic [MS_W-1:0]       RST_TRANSITION    = MS_W'(0);
    localparam logic [LEVEL_BITS-1:0] RST_MIN_LEVEL     = LEVEL_BITS'(100);
    localparam logic [LEVEL_BITS-1:0] RST_STEP_SIZE     = LEVEL_BITS'(50);
    localparam logic [LEVEL_BITS-1:0] RST_CLICK_LEVEL   = LEVEL_BITS'(1023);

    // Item opcodes.
    typedef enum logic [1:0] {
        OP_PRESS   = 2'd0,
        OP_RELEASE = 2'd1,
        OP_TICK    = 2'd2
    } op_e;

    // Result commands.
    localparam logic CMD_ON  = 1'b0;
    localparam logic CMD_OFF = 1'b1;

    // Register indexes on the configuration port.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_HOLD_DELAY    = 3'd0,
        CFG_STEP_INTERVAL = 3'd1,
        CFG_TRANSITION    = 3'd2,
        CFG_MIN_LEVEL     = 3'd3,
        CFG_STEP_SIZE     = 3'd4,
        CFG_CLICK_LEVEL   = 3'd5
    } cfg_idx_e;

    typedef struct packed {
        logic [1:0]            op;
        logic                  light_on;
        logic [LEVEL_BITS-1:0] light_level;
    } in_item_t;

    typedef struct packed {
        logic                  command;
        logic [LEVEL_BITS-1:0] level;
        logic                  with_transition;
    } out_item_t;

    typedef struct packed {
        logic [MS_W-1:0]       hold_delay_ms;
        logic [MS_W-1:0]       step_interval_ms;
        logic [MS_W-1:0]       transition_ms;
        logic [LEVEL_BITS-1:0] min_level;
        logic [LEVEL_BITS-1:0] step_size;
        logic [LEVEL_BITS-1:0] click_level;
    } cfg_t;

    typedef struct packed {
        logic              pressed;
        logic              holding;
        logic              dir_down;
        logic [MS_W-1:0]   press_elapsed;
        logic [WAIT_W-1:0] step_wait;
    } state_t;

endpackage

>>> rtl/hold_to_dim_button_controller.sv
// Single-button dimmer controller. Items are press, release and one-millisecond
// tick events, each carrying the light's reported on flag and level; a click
// toggles the light and a long press dims it up or down in hold mode. The block
// takes one item per clock cycle: an item is captured in an input register, then
// the state update and the at most one resulting command are computed in a single
// pass and stored in the output register. An item that yields no command passes on
// even while a command waits on the output; input ready drops only when a
// command is waiting and the item in the input register yields another one.
// Configuration registers take effect on the next item and are to be written by
// the user only while the block is idle; the block itself does not enforce this.
module hold_to_dim_button_controller
    import hdbc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  in_item_t              in_item,
    output logic                  out_valid,
    input  logic                  out_ready,
    output out_item_t             out_item,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t      cfg_reg;
    state_t    state_reg;
    state_t    state_next;
    logic      s1_valid_reg;
    in_item_t  s1_item_reg;
    logic      out_valid_reg;
    out_item_t out_item_reg;
    out_item_t res;
    logic      has_res;
    logic      advance;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.hold_delay_ms    <= RST_HOLD_DELAY;
            cfg_reg.step_interval_ms <= RST_STEP_INTERVAL;
            cfg_reg.transition_ms    <= RST_TRANSITION;
            cfg_reg.min_level        <= RST_MIN_LEVEL;
            cfg_reg.step_size        <= RST_STEP_SIZE;
            cfg_reg.click_level      <= RST_CLICK_LEVEL;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_HOLD_DELAY:    cfg_reg.hold_delay_ms    <= cfg_data[MS_W-1:0];
                CFG_STEP_INTERVAL: cfg_reg.step_interval_ms <= cfg_data[MS_W-1:0];
                CFG_TRANSITION:    cfg_reg.transition_ms    <= cfg_data[MS_W-1:0];
                CFG_MIN_LEVEL:     cfg_reg.min_level        <= cfg_data[LEVEL_BITS-1:0];
                CFG_STEP_SIZE:     cfg_reg.step_size        <= cfg_data[LEVEL_BITS-1:0];
                CFG_CLICK_LEVEL:   cfg_reg.click_level      <= cfg_data[LEVEL_BITS-1:0];
                default:           cfg_reg                  <= cfg_reg;
            endcase
        end
    end

    // Per-item state update and result.
    hdbc_core u_core (
        .st      (state_reg),
        .cfg     (cfg_reg),
        .item    (s1_item_reg),
        .st_next (state_next),
        .res     (res),
        .has_res (has_res)
    );

    // The held item moves on unless it has a command and the output is blocked.
    assign advance  = s1_valid_reg && (!out_valid_reg || out_ready || !has_res);
    assign in_ready = !s1_valid_reg || advance;

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_item_reg <= in_item;
        end
    end

    // Controller state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '0;
        end
        else if (advance)
        begin
            state_reg <= state_next;
        end
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance && has_res)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && has_res)
        begin
            out_item_reg <= res;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

endmodule

>>> rtl/hdbc_core.sv
module hdbc_core
    import hdbc_pkg::*;
(
    input  state_t    st,
    input  cfg_t      cfg,
    input  in_item_t  item,
    output state_t    st_next,
    output out_item_t res,
    output logic      has_res
);

    logic [MS_W-1:0]       pe_inc;
    logic [WAIT_W-1:0]     sw_dec;
    logic [WAIT_W-1:0]     interval_ext;
    logic [WAIT_W-1:0]     interval_x3;
    logic                  step_dir;
    logic [LEVEL_BITS:0]   down_floor;
    logic                  down_ok;
    logic [LEVEL_BITS-1:0] down_level;
    logic [LEVEL_BITS:0]   up_sum;
    logic                  up_ok;
    logic [LEVEL_BITS-1:0] up_level;
    logic                  step_ok;
    logic [LEVEL_BITS-1:0] step_level;

    // Timers: the press counter saturates, the step timer stops at zero.
    assign pe_inc       = (st.press_elapsed != MS_MAX) ? st.press_elapsed + MS_W'(1)
                                                       : st.press_elapsed;
    assign sw_dec       = (st.step_wait != '0) ? st.step_wait - WAIT_W'(1) : '0;
    assign interval_ext = WAIT_W'(cfg.step_interval_ms);
    assign interval_x3  = {1'b0, cfg.step_interval_ms, 1'b0} + interval_ext;

    // A step taken on entering hold mode uses the freshly reversed direction.
    assign step_dir = st.holding ? st.dir_down : ~st.dir_down;

    // Going down stops once the new level would reach the minimum.
    assign down_floor = {1'b0, cfg.step_size} + {1'b0, cfg.min_level};
    assign down_ok    = {1'b0, item.light_level} > down_floor;
    assign down_level = item.light_level - cfg.step_size;

    // Going up clamps to full scale and does nothing once there.
    assign up_sum   = {1'b0, item.light_level} + {1'b0, cfg.step_size};
    assign up_ok    = item.light_level != LEVEL_FULL;
    assign up_level = (up_sum > {1'b0, LEVEL_FULL}) ? LEVEL_FULL : up_sum[LEVEL_BITS-1:0];

    assign step_ok    = item.light_on && (step_dir ? down_ok : up_ok);
    assign step_level = step_dir ? down_level : up_level;

    // Next state and result for one item.
    always_comb
    begin
        st_next = st;
        res     = '0;
        has_res = 1'b0;
        case (item.op)
            OP_PRESS:
            begin
                st_next.pressed       = 1'b1;
                st_next.holding       = 1'b0;
                st_next.press_elapsed = '0;
                st_next.step_wait     = '0;
            end
            OP_RELEASE:
            begin
                st_next.pressed = 1'b0;
                st_next.holding = 1'b0;
                if (!st.holding)
                begin
                    has_res = 1'b1;
                    if (!item.light_on)
                    begin
                        st_next.dir_down = 1'b0;
                        res.command      = CMD_ON;
                        res.level        = cfg.click_level;
                    end
                    else
                    begin
                        res.command = CMD_OFF;
                    end
                end
            end
            OP_TICK:
            begin
                if (st.pressed)
                begin
                    st_next.press_elapsed = pe_inc;
                    if (!st.holding)
                    begin
                        if (pe_inc >= cfg.hold_delay_ms)
                        begin
                            st_next.holding = 1'b1;
                            if (!item.light_on)
                            begin
                                // Turn on at the minimum, then wait three intervals.
                                st_next.dir_down    = 1'b0;
                                st_next.step_wait   = interval_x3;
                                has_res             = 1'b1;
                                res.command         = CMD_ON;
                                res.level           = cfg.min_level;
                                res.with_transition = 1'b1;
                            end
                            else
                            begin
                                st_next.dir_down    = ~st.dir_down;
                                st_next.step_wait   = interval_ext;
                                has_res             = step_ok;
                                res.command         = CMD_ON;
                                res.level           = step_level;
                                res.with_transition = 1'b1;
                            end
                        end
                    end
                    else if (sw_dec != '0)
                    begin
                        st_next.step_wait = sw_dec;
                    end
                    else
                    begin
                        st_next.step_wait   = interval_ext;
                        has_res             = step_ok;
                        res.command         = CMD_ON;
                        res.level           = step_level;
                        res.with_transition = 1'b1;
                    end
                end
            end
            default:
            begin
                st_next = st;
            end
        endcase
    end

endmodule

>>> rtl/hdbc_checker.sv
module hdbc_checker
    import hdbc_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  in_valid,
    input logic                  in_ready,
    input logic                  out_valid,
    input logic                  out_ready,
    input out_item_t             out_item
);

    // A waiting command holds until it is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_item))
    else $error("output item changed or dropped while stalled");

    // Turn-off only comes from a click: level zero and no transition.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_item.command == CMD_OFF
        |-> out_item.level == '0 && !out_item.with_transition)
    else $error("turn-off command carries a level or transition");

    // A new command on an empty output comes from an item taken without a stall.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && in_ready, 2))
    else $error("command appeared without a matching input item");

    // Input is only held off by a blocked output.
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
    else $error("input stalled while output is free");

endmodule

bind hold_to_dim_button_controller hdbc_checker u_hdbc_checker (.*);

>>> tb/testbench.sv
`timescale 1ns / 100ps

module testbench;
    import hdbc_pkg::*;

    localparam int          CYCLE_LIMIT = 2_000_000;
    localparam int          MAX_LINES   = 20;
    // The op code that the block has no meaning for.
    localparam logic [1:0]  OP_UNUSED   = 2'd3;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    logic                  in_ready;
    in_item_t              in_item   = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    out_item_t             out_item;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = CFG_HOLD_DELAY;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    // Button events waiting to be driven and commands the dimmer should issue.
    in_item_t  button_events[$];
    out_item_t pending_commands[$];
    int        events_queued = 0;
    int        events_taken  = 0;
    int        mismatches    = 0;
    int        cycles        = 0;
    bit        in_taken      = 1'b0;
    bit        no_gaps       = 1'b0;

    // Shadow copy of the dimmer's settings and button state.
    cfg_t              dimmer_cfg;
    bit                btn_down   = 1'b0;
    bit                in_hold    = 1'b0;
    bit                going_down = 1'b0;
    logic [MS_W-1:0]   held_ms    = '0;
    logic [WAIT_W-1:0] ms_to_step = '0;

    hold_to_dim_button_controller u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // One dimming step: reload the step timer and move the level, if possible.
    function automatic bit dim_step(input bit on, input int lvl, output out_item_t cmd);
        int nl;
        ms_to_step = WAIT_W'(dimmer_cfg.step_interval_ms);
        cmd = '0;
        if (!on)
            return 1'b0;
        if (going_down)
        begin
            nl = lvl - int'(dimmer_cfg.step_size);
            if (nl <= int'(dimmer_cfg.min_level))
                return 1'b0;
        end
        else
        begin
            if (lvl >= int'(LEVEL_FULL))
                return 1'b0;
            nl = lvl + int'(dimmer_cfg.step_size);
            if (nl > int'(LEVEL_FULL))
                nl = int'(LEVEL_FULL);
        end
        cmd.command         = CMD_ON;
        cmd.level           = LEVEL_BITS'(nl);
        cmd.with_transition = 1'b1;
        return 1'b1;
    endfunction

    // Works out the command, if any, that one button event causes.
    function automatic bit predict_command(input in_item_t ev, output out_item_t cmd);
        bit had_hold;
        cmd = '0;
        case (ev.op)
            OP_PRESS:
            begin
                btn_down   = 1'b1;
                in_hold    = 1'b0;
                held_ms    = '0;
                ms_to_step = '0;
                return 1'b0;
            end
            OP_RELEASE:
            begin
                had_hold = in_hold;
                btn_down = 1'b0;
                in_hold  = 1'b0;
                if (had_hold)
                    return 1'b0;
                if (!ev.light_on)
                begin
                    going_down = 1'b0;
                    cmd.command = CMD_ON;
                    cmd.level   = dimmer_cfg.click_level;
                end
                else
                    cmd.command = CMD_OFF;
                return 1'b1;
            end
            OP_TICK:
            begin
                if (!btn_down)
                    return 1'b0;
                if (held_ms != MS_MAX)
                    held_ms++;
                if (!in_hold)
                begin
                    if (held_ms < dimmer_cfg.hold_delay_ms)
                        return 1'b0;
                    in_hold = 1'b1;
                    if (!ev.light_on)
                    begin
                        // Hold from off: light up at the minimum and wait three intervals.
                        going_down = 1'b0;
                        ms_to_step = WAIT_W'(3 * dimmer_cfg.step_interval_ms);
                        cmd.command         = CMD_ON;
                        cmd.level           = dimmer_cfg.min_level;
                        cmd.with_transition = 1'b1;
                        return 1'b1;
                    end
                    going_down = !going_down;
                    return dim_step(ev.light_on, int'(ev.light_level), cmd);
                end
                if (ms_to_step != 0)
                    ms_to_step--;
                if (ms_to_step != 0)
                    return 1'b0;
                return dim_step(ev.light_on, int'(ev.light_level), cmd);
            end
            default:
                return 1'b0;
        endcase
    endfunction

    task automatic note_mismatch(input string what, input int got, input int want);
        if (mismatches < MAX_LINES)
            $display("MISMATCH at cycle %0d: %s got %0d, expected %0d", cycles, what, got, want);
        mismatches++;
    endtask

    // Drive the next button event and the result stall at the falling edge.
    always @(negedge clk)
    begin
        if (!in_valid || in_taken)
        begin
            if (button_events.size() != 0 && (no_gaps || $urandom_range(99) >= 10))
            begin
                in_valid <= 1'b1;
                in_item  <= button_events.pop_front();
            end
            else
                in_valid <= 1'b0;
        end
        out_ready <= no_gaps || ($urandom_range(99) >= 10);
    end

    // Check issued commands, then predict for the event taken at this edge.
    always @(posedge clk)
    begin
        out_item_t want;
        out_item_t cmd;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_commands.size() == 0)
                note_mismatch("unexpected command, level", int'(out_item.level), 0);
            else
            begin
                want = pending_commands.pop_front();
                if (out_item.command !== want.command)
                    note_mismatch("command", int'(out_item.command), int'(want.command));
                if (out_item.level !== want.level)
                    note_mismatch("level", int'(out_item.level), int'(want.level));
                if (out_item.with_transition !== want.with_transition)
                    note_mismatch("with_transition", int'(out_item.with_transition),
                                  int'(want.with_transition));
            end
        end
        in_taken = rst_n && in_valid && in_ready;
        if (in_taken)
        begin
            events_taken++;
            if (predict_command(in_item, cmd))
                pending_commands.push_back(cmd);
        end
    end

    // Run limit.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    function automatic void queue_item(input logic [1:0] op, input bit on,
                                       input logic [LEVEL_BITS-1:0] lvl);
        in_item_t ev;
        ev.op          = op;
        ev.light_on    = on;
        ev.light_level = lvl;
        button_events.push_back(ev);
        events_queued++;
    endfunction

    // Mostly random brightness, with the two ends of the scale now and then.
    function automatic logic [LEVEL_BITS-1:0] pick_level();
        case ($urandom_range(9))
            0: return '0;
            1: return LEVEL_FULL;
            default: return LEVEL_BITS'($urandom);
        endcase
    endfunction

    // A press, some ticks and a release; the light mostly keeps its state.
    function automatic void queue_gesture(input int ticks);
        bit on;
        on = 1'($urandom_range(1));
        queue_item(OP_PRESS, on, pick_level());
        for (int i = 0; i < ticks; i++)
        begin
            if ($urandom_range(9) == 0)
                on = !on;
            queue_item(OP_TICK, on, pick_level());
        end
        queue_item(OP_RELEASE, on, pick_level());
    endfunction

    task automatic wait_drained();
        while (events_taken != events_queued || pending_commands.size() != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_idx_e idx, input logic [CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        case (idx)
            CFG_HOLD_DELAY:    dimmer_cfg.hold_delay_ms    = value[MS_W-1:0];
            CFG_STEP_INTERVAL: dimmer_cfg.step_interval_ms = value[MS_W-1:0];
            CFG_TRANSITION:    dimmer_cfg.transition_ms    = value[MS_W-1:0];
            CFG_MIN_LEVEL:     dimmer_cfg.min_level        = value[LEVEL_BITS-1:0];
            CFG_STEP_SIZE:     dimmer_cfg.step_size        = value[LEVEL_BITS-1:0];
            CFG_CLICK_LEVEL:   dimmer_cfg.click_level      = value[LEVEL_BITS-1:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic apply_setting(input cfg_t s);
        wait_drained();
        write_reg(CFG_HOLD_DELAY, CFG_DATA_W'(s.hold_delay_ms));
        write_reg(CFG_STEP_INTERVAL, CFG_DATA_W'(s.step_interval_ms));
        write_reg(CFG_TRANSITION, CFG_DATA_W'(s.transition_ms));
        write_reg(CFG_MIN_LEVEL, CFG_DATA_W'(s.min_level));
        write_reg(CFG_STEP_SIZE, CFG_DATA_W'(s.step_size));
        write_reg(CFG_CLICK_LEVEL, CFG_DATA_W'(s.click_level));
    endtask

    initial
    begin
        cfg_t s;
        int   count;
        int   n;
        bit   paused;
        dimmer_cfg.hold_delay_ms    = RST_HOLD_DELAY;
        dimmer_cfg.step_interval_ms = RST_STEP_INTERVAL;
        dimmer_cfg.transition_ms    = RST_TRANSITION;
        dimmer_cfg.min_level        = RST_MIN_LEVEL;
        dimmer_cfg.step_size        = RST_STEP_SIZE;
        dimmer_cfg.click_level      = RST_CLICK_LEVEL;
        paused = 1'b0;

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: short hold delay and a one-tick interval.
        s = '{hold_delay_ms: 3, step_interval_ms: 1, transition_ms: 7,
              min_level: 100, step_size: 300, click_level: LEVEL_FULL};
        apply_setting(s);
        // Release without press counts as a click, from off and from on.
        queue_item(OP_RELEASE, 1'b0, 10'd512);
        queue_item(OP_RELEASE, 1'b1, LEVEL_FULL);
        // Unused op and a tick with no button down do nothing.
        queue_item(OP_UNUSED, 1'b1, '0);
        queue_item(OP_TICK, 1'b0, '0);
        // Press while pressed restarts timing; hold from off, then step up to full.
        queue_item(OP_PRESS, 1'b0, '0);
        queue_item(OP_PRESS, 1'b0, '0);
        repeat (3) queue_item(OP_TICK, 1'b0, '0);
        repeat (3) queue_item(OP_TICK, 1'b1, 10'd1000);
        queue_item(OP_TICK, 1'b1, LEVEL_FULL);
        queue_item(OP_RELEASE, 1'b1, LEVEL_FULL);
        // Hold from on dims down, stops near the minimum, then a step with light off.
        queue_item(OP_PRESS, 1'b1, 10'd500);
        repeat (3) queue_item(OP_TICK, 1'b1, 10'd500);
        queue_item(OP_TICK, 1'b1, 10'd350);
        queue_item(OP_TICK, 1'b0, 10'd350);
        queue_item(OP_RELEASE, 1'b0, 10'd350);
        // Next hold from on reverses the direction back to up.
        queue_item(OP_PRESS, 1'b1, 10'd700);
        repeat (3) queue_item(OP_TICK, 1'b1, 10'd700);
        queue_item(OP_RELEASE, 1'b1, 10'd1000);

        // A longer hold delay; once holding, a step on every tick.
        s = '{hold_delay_ms: 20, step_interval_ms: 1, transition_ms: MS_MAX,
              min_level: 0, step_size: LEVEL_FULL, click_level: 0};
        apply_setting(s);
        queue_item(OP_PRESS, 1'b1, pick_level());
        repeat (25) queue_item(OP_TICK, 1'b1, pick_level());
        queue_item(OP_RELEASE, 1'b1, pick_level());
        queue_item(OP_RELEASE, 1'b0, pick_level());
        queue_item(OP_RELEASE, 1'b1, pick_level());

        // Immediate hold from off, then a long wait to the first step.
        s = '{hold_delay_ms: 0, step_interval_ms: 40, transition_ms: 0,
              min_level: LEVEL_FULL, step_size: 0, click_level: LEVEL_FULL};
        apply_setting(s);
        queue_item(OP_PRESS, 1'b0, '0);
        queue_item(OP_TICK, 1'b0, '0);
        repeat (3 * int'(s.step_interval_ms) - 1)
            queue_item(OP_TICK, 1'($urandom_range(1)), pick_level());
        queue_item(OP_TICK, 1'b1, 10'd1022);
        queue_item(OP_RELEASE, 1'b1, 10'd1022);
        queue_item(OP_RELEASE, 1'b0, '0);

        // Random gestures with some noise, under a new setting each time.
        for (int ph = 0; ph < 8; ph++)
        begin
            s.hold_delay_ms    = MS_W'($urandom_range(12));
            s.step_interval_ms = (ph == 0) ? '0 : MS_W'($urandom_range(4));
            s.transition_ms    = MS_W'($urandom);
            s.min_level        = pick_level();
            s.step_size        = pick_level();
            s.click_level      = pick_level();
            apply_setting(s);
            no_gaps = (ph == 3);
            count = 0;
            while (count < 140)
            begin
                if ($urandom_range(99) < 80)
                begin
                    n = $urandom_range(int'(s.hold_delay_ms) + 4 * int'(s.step_interval_ms) + 6);
                    queue_gesture(n);
                    count += n + 2;
                end
                else
                begin
                    queue_item(2'($urandom), 1'($urandom_range(1)), pick_level());
                    count++;
                end
                // Hold off once mid-phase until every command has come.
                if (ph == 5 && count >= 70 && !paused)
                begin
                    wait_drained();
                    paused = 1'b1;
                end
            end
        end
        no_gaps = 1'b0;

        wait_drained();
        repeat (10) @(posedge clk);
        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

>>> hold_to_dim_button_controller.f
rtl/hdbc_pkg.sv
rtl/hdbc_core.sv
rtl/hold_to_dim_button_controller.sv
rtl/hdbc_checker.sv
tb/testbench.sv
